>>> rtl/urs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL risk scorer package
// Shared widths, codes, reset values, feature weights and byte constants.
// ----------------------------------------------------------------------------
package urs_pkg;

	// Field and register widths.
	localparam int CHAR_W      = 8;
	localparam int LEN_W       = 16;
	localparam int COUNT_W     = 8;
	localparam int SCORE_W     = 6;
	localparam int VERDICT_W   = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int PART_W      = 9;
	localparam int RUN_DOTS_W  = 3;
	localparam int PREFIX_W    = 4;
	localparam int WINDOW_W    = 48;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LENGTH_LIMIT      = 3'd0,
		REG_DOT_LIMIT         = 3'd1,
		REG_PERCENT_LIMIT     = 3'd2,
		REG_HIGH_THRESHOLD    = 3'd3,
		REG_SUSPECT_THRESHOLD = 3'd4
	} reg_idx_t;

	// Reset values of the configuration registers.
	localparam logic [LEN_W-1:0]   RST_LENGTH_LIMIT      = 16'd120;
	localparam logic [COUNT_W-1:0] RST_DOT_LIMIT         = 8'd6;
	localparam logic [COUNT_W-1:0] RST_PERCENT_LIMIT     = 8'd2;
	localparam logic [SCORE_W-1:0] RST_HIGH_THRESHOLD    = 6'd30;
	localparam logic [SCORE_W-1:0] RST_SUSPECT_THRESHOLD = 6'd15;

	// Dotted-quad decision for the current URL.
	typedef enum logic [1:0] {
		IP_UNDECIDED = 2'd0,
		IP_FOUND     = 2'd1,
		IP_RULED_OUT = 2'd2
	} ip_status_t;

	// Verdict codes.
	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_LOW        = 2'd0,
		VERDICT_SUSPICIOUS = 2'd1,
		VERDICT_HIGH       = 2'd2
	} verdict_t;

	// Feature weights.
	localparam logic [SCORE_W-1:0] W_TOO_LONG     = 6'd10;
	localparam logic [SCORE_W-1:0] W_AT_SIGN      = 6'd8;
	localparam logic [SCORE_W-1:0] W_IP_ADDRESS   = 6'd12;
	localparam logic [SCORE_W-1:0] W_NO_HTTPS     = 6'd6;
	localparam logic [SCORE_W-1:0] W_KEYWORD      = 6'd10;
	localparam logic [SCORE_W-1:0] W_MANY_DOTS    = 6'd6;
	localparam logic [SCORE_W-1:0] W_MANY_PERCENT = 6'd6;
	localparam logic [SCORE_W-1:0] SCORE_MAX      = 6'd58;

	// Saturation points.
	localparam logic [LEN_W-1:0]      LEN_MAX      = 16'hFFFF;
	localparam logic [COUNT_W-1:0]    COUNT_MAX    = 8'hFF;
	localparam logic [PART_W-1:0]     PART_SAT     = 9'd256;
	localparam logic [PART_W-1:0]     PART_MAX_OK  = 9'd255;
	localparam logic [RUN_DOTS_W-1:0] RUN_DOTS_SAT = 3'd4;
	localparam logic [RUN_DOTS_W-1:0] QUAD_DOTS    = 3'd3;

	// Prefix matcher positions.
	localparam logic [PREFIX_W-1:0] PREFIX_DONE = 4'd8;
	localparam logic [PREFIX_W-1:0] PREFIX_FAIL = 4'd15;

	// Byte constants.
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_AT      = 8'h40;
	localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

	// Keywords, lowercase, newest byte lowest.
	localparam logic [39:0]         KEY_LOGIN  = 40'h6C6F67696E;
	localparam logic [WINDOW_W-1:0] KEY_VERIFY = 48'h766572696679;
	localparam logic [WINDOW_W-1:0] KEY_UPDATE = 48'h757064617465;
	localparam logic [WINDOW_W-1:0] KEY_SECURE = 48'h736563757265;

	// Expected byte at each position of the secure prefix.
	function automatic logic [CHAR_W-1:0] prefix_char(input logic [2:0] pos);
		logic [CHAR_W-1:0] ch;
		case (pos)
			3'd0:    ch = 8'h68; // h
			3'd1:    ch = 8'h74; // t
			3'd2:    ch = 8'h74; // t
			3'd3:    ch = 8'h70; // p
			3'd4:    ch = 8'h73; // s
			3'd5:    ch = 8'h3A; // :
			3'd6:    ch = 8'h2F; // /
			default: ch = 8'h2F; // /
		endcase
		return ch;
	endfunction

endpackage

>>> rtl/urs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL risk scorer channels
// Valid/ready channels for URL bytes in and risk results out.
// ----------------------------------------------------------------------------
interface urs_in_if;
	import urs_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_byte;
	logic              has_char;
	logic              last;

	modport source (output valid, output char_byte, output has_char, output last,
		input ready);
	modport sink (input valid, input char_byte, input has_char, input last,
		output ready);
endinterface

interface urs_out_if;
	import urs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [SCORE_W-1:0]   score;
	logic [VERDICT_W-1:0] verdict;
	logic                 too_long;
	logic                 at_sign;
	logic                 ip_address;
	logic                 no_https;
	logic                 keyword;
	logic                 many_dots;
	logic                 many_percent;

	modport source (output valid, output score, output verdict, output too_long,
		output at_sign, output ip_address, output no_https, output keyword,
		output many_dots, output many_percent, input ready);
	modport sink (input valid, input score, input verdict, input too_long,
		input at_sign, input ip_address, input no_https, input keyword,
		input many_dots, input many_percent, output ready);
endinterface

>>> rtl/url_risk_scorer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL risk scorer core
// Scores one URL, given a byte per transfer, for seven phishing features.
// ----------------------------------------------------------------------------
// The block takes one URL byte per cycle and accepts a new byte in every
// cycle while no waiting result holds input off. Each byte is captured in an
// input register and folded from there into the per-URL feature state. The
// transfer marked last also loads the result register with the score,
// verdict and flags; the result passes through the input register and the
// result register before it is presented. A waiting result stalls input
// only when another last byte is ready to be scored behind it. After each
// result all per-URL state clears; the configuration registers keep
// their values and should be written only while no URL is in progress.
module url_risk_scorer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [urs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [urs_pkg::CFG_DATA_W-1:0] cfg_data,
	urs_in_if.sink                         url_in,
	urs_out_if.source                      risk_out
);
	import urs_pkg::*;

	// Configuration registers.
	logic [LEN_W-1:0]   length_limit_q;
	logic [COUNT_W-1:0] dot_limit_q;
	logic [COUNT_W-1:0] percent_limit_q;
	logic [SCORE_W-1:0] high_threshold_q;
	logic [SCORE_W-1:0] suspect_threshold_q;

	// Input stage.
	logic              valid_s1;
	logic [CHAR_W-1:0] char_byte_s1;
	logic              has_char_s1;
	logic              last_s1;

	// Per-URL feature state.
	logic [LEN_W-1:0]      length_count_q, length_count_n;
	logic                  at_seen_q, at_seen_n;
	ip_status_t            ip_status_q, ip_status_n, ip_final;
	logic                  in_run_q, in_run_n;
	logic                  part_empty_q, part_empty_n;
	logic [PART_W-1:0]     part_value_q, part_value_n;
	logic [RUN_DOTS_W-1:0] run_dots_q, run_dots_n;
	logic [PREFIX_W-1:0]   prefix_position_q, prefix_position_n;
	logic [WINDOW_W-1:0]   recent_window_q, recent_window_n;
	logic                  keyword_seen_q, keyword_seen_n;
	logic [COUNT_W-1:0]    dot_count_q, dot_count_n;
	logic [COUNT_W-1:0]    percent_count_q, percent_count_n;

	// Result register.
	logic                 out_valid_q;
	logic [SCORE_W-1:0]   score_q;
	logic [VERDICT_W-1:0] verdict_q;
	logic                 too_long_q, at_sign_q, ip_address_q, no_https_q;
	logic                 keyword_q, many_dots_q, many_percent_q;

	// Per-byte working signals.
	logic                 proc;
	logic                 out_free;
	logic [CHAR_W-1:0]    low;
	logic                 is_digit;
	logic [3:0]           digit_val;
	logic [11:0]          part_mul;
	logic                 f_long, f_at, f_ip, f_https, f_key, f_dots, f_pct;
	logic [SCORE_W-1:0]   score_c;
	verdict_t             verdict_c;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_limit_q      <= RST_LENGTH_LIMIT;
			dot_limit_q         <= RST_DOT_LIMIT;
			percent_limit_q     <= RST_PERCENT_LIMIT;
			high_threshold_q    <= RST_HIGH_THRESHOLD;
			suspect_threshold_q <= RST_SUSPECT_THRESHOLD;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LENGTH_LIMIT:      length_limit_q      <= cfg_data;
				REG_DOT_LIMIT:         dot_limit_q         <= cfg_data[COUNT_W-1:0];
				REG_PERCENT_LIMIT:     percent_limit_q     <= cfg_data[COUNT_W-1:0];
				REG_HIGH_THRESHOLD:    high_threshold_q    <= cfg_data[SCORE_W-1:0];
				REG_SUSPECT_THRESHOLD: suspect_threshold_q <= cfg_data[SCORE_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: a byte is processed unless it must load a result that has
	// nowhere to go yet.
	assign out_free     = !out_valid_q || risk_out.ready;
	assign proc         = valid_s1 && (!last_s1 || out_free);
	assign url_in.ready = !valid_s1 || proc;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (url_in.ready) begin
			valid_s1 <= url_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (url_in.ready && url_in.valid) begin
			char_byte_s1 <= url_in.char_byte;
			has_char_s1  <= url_in.has_char;
			last_s1      <= url_in.last;
		end
	end

	// Byte classification.
	always_comb begin
		low       = (char_byte_s1 inside {[CH_UPPER_A:CH_UPPER_Z]}) ?
			char_byte_s1 + CASE_DIFF : char_byte_s1;
		is_digit  = char_byte_s1 inside {[CH_ZERO:CH_NINE]};
		digit_val = 4'(char_byte_s1 - CH_ZERO);
		part_mul  = 12'({part_value_q, 3'b000}) + 12'({part_value_q, 1'b0}) +
			12'(digit_val);
	end

	// Counters, prefix matcher and keyword window after this byte.
	always_comb begin
		length_count_n    = length_count_q;
		at_seen_n         = at_seen_q;
		dot_count_n       = dot_count_q;
		percent_count_n   = percent_count_q;
		prefix_position_n = prefix_position_q;
		recent_window_n   = recent_window_q;
		keyword_seen_n    = keyword_seen_q;
		if (has_char_s1) begin
			if (length_count_q != LEN_MAX) length_count_n = length_count_q + 1'b1;
			if (char_byte_s1 == CH_AT) at_seen_n = 1'b1;
			if (char_byte_s1 == CH_DOT && dot_count_q != COUNT_MAX)
				dot_count_n = dot_count_q + 1'b1;
			if (char_byte_s1 == CH_PERCENT && percent_count_q != COUNT_MAX)
				percent_count_n = percent_count_q + 1'b1;
			if (prefix_position_q < PREFIX_DONE) begin
				prefix_position_n = (low == prefix_char(prefix_position_q[2:0])) ?
					prefix_position_q + 1'b1 : PREFIX_FAIL;
			end
			recent_window_n = {recent_window_q[WINDOW_W-CHAR_W-1:0], low};
			if (recent_window_n[39:0] == KEY_LOGIN || recent_window_n == KEY_VERIFY ||
				recent_window_n == KEY_UPDATE || recent_window_n == KEY_SECURE)
				keyword_seen_n = 1'b1;
		end
	end

	// Dotted-quad run tracker after this byte.
	always_comb begin
		ip_status_n  = ip_status_q;
		in_run_n     = in_run_q;
		part_empty_n = part_empty_q;
		part_value_n = part_value_q;
		run_dots_n   = run_dots_q;
		if (has_char_s1 && ip_status_q == IP_UNDECIDED) begin
			if (!in_run_q) begin
				if (is_digit) begin
					in_run_n     = 1'b1;
					part_empty_n = 1'b0;
					part_value_n = PART_W'(digit_val);
					run_dots_n   = '0;
				end
			end else if (is_digit) begin
				part_value_n = (part_mul > 12'(PART_SAT)) ? PART_SAT : part_mul[PART_W-1:0];
				part_empty_n = 1'b0;
			end else if (char_byte_s1 == CH_DOT) begin
				if (part_empty_q || part_value_q > PART_MAX_OK) begin
					ip_status_n = IP_RULED_OUT;
				end else begin
					part_empty_n = 1'b1;
					part_value_n = '0;
					if (run_dots_q != RUN_DOTS_SAT) run_dots_n = run_dots_q + 1'b1;
				end
			end else begin
				if (!part_empty_q && part_value_q > PART_MAX_OK) ip_status_n = IP_RULED_OUT;
				else if (run_dots_q == QUAD_DOTS) ip_status_n = IP_FOUND;
				in_run_n = 1'b0;
			end
		end
	end

	// Close an open run at the end of the URL, then score it.
	always_comb begin
		ip_final = ip_status_n;
		if (in_run_n && ip_status_n == IP_UNDECIDED) begin
			if (!part_empty_n && part_value_n > PART_MAX_OK) ip_final = IP_RULED_OUT;
			else if (run_dots_n == QUAD_DOTS) ip_final = IP_FOUND;
		end
		f_long  = length_count_n > length_limit_q;
		f_at    = at_seen_n;
		f_ip    = ip_final == IP_FOUND;
		f_https = prefix_position_n != PREFIX_DONE;
		f_key   = keyword_seen_n;
		f_dots  = dot_count_n > dot_limit_q;
		f_pct   = percent_count_n > percent_limit_q;
		score_c = (f_long  ? W_TOO_LONG     : '0) + (f_at   ? W_AT_SIGN   : '0) +
			(f_ip    ? W_IP_ADDRESS   : '0) + (f_https ? W_NO_HTTPS  : '0) +
			(f_key   ? W_KEYWORD      : '0) + (f_dots  ? W_MANY_DOTS : '0) +
			(f_pct   ? W_MANY_PERCENT : '0);
		if (score_c >= high_threshold_q)         verdict_c = VERDICT_HIGH;
		else if (score_c >= suspect_threshold_q) verdict_c = VERDICT_SUSPICIOUS;
		else                                     verdict_c = VERDICT_LOW;
	end

	// Feature state: update on each processed byte, clear after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_count_q    <= '0;
			at_seen_q         <= 1'b0;
			ip_status_q       <= IP_UNDECIDED;
			in_run_q          <= 1'b0;
			part_empty_q      <= 1'b1;
			part_value_q      <= '0;
			run_dots_q        <= '0;
			prefix_position_q <= '0;
			recent_window_q   <= '0;
			keyword_seen_q    <= 1'b0;
			dot_count_q       <= '0;
			percent_count_q   <= '0;
		end else if (proc) begin
			if (last_s1) begin
				length_count_q    <= '0;
				at_seen_q         <= 1'b0;
				ip_status_q       <= IP_UNDECIDED;
				in_run_q          <= 1'b0;
				part_empty_q      <= 1'b1;
				part_value_q      <= '0;
				run_dots_q        <= '0;
				prefix_position_q <= '0;
				recent_window_q   <= '0;
				keyword_seen_q    <= 1'b0;
				dot_count_q       <= '0;
				percent_count_q   <= '0;
			end else begin
				length_count_q    <= length_count_n;
				at_seen_q         <= at_seen_n;
				ip_status_q       <= ip_status_n;
				in_run_q          <= in_run_n;
				part_empty_q      <= part_empty_n;
				part_value_q      <= part_value_n;
				run_dots_q        <= run_dots_n;
				prefix_position_q <= prefix_position_n;
				recent_window_q   <= recent_window_n;
				keyword_seen_q    <= keyword_seen_n;
				dot_count_q       <= dot_count_n;
				percent_count_q   <= percent_count_n;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (risk_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			score_q        <= score_c;
			verdict_q      <= verdict_c;
			too_long_q     <= f_long;
			at_sign_q      <= f_at;
			ip_address_q   <= f_ip;
			no_https_q     <= f_https;
			keyword_q      <= f_key;
			many_dots_q    <= f_dots;
			many_percent_q <= f_pct;
		end
	end

	assign risk_out.valid        = out_valid_q;
	assign risk_out.score        = score_q;
	assign risk_out.verdict      = verdict_q;
	assign risk_out.too_long     = too_long_q;
	assign risk_out.at_sign      = at_sign_q;
	assign risk_out.ip_address   = ip_address_q;
	assign risk_out.no_https     = no_https_q;
	assign risk_out.keyword      = keyword_q;
	assign risk_out.many_dots    = many_dots_q;
	assign risk_out.many_percent = many_percent_q;

`ifndef SYNTHESIS
	// A decided IP status holds until the URL closes.
	a_ip_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(ip_status_q != IP_UNDECIDED && !(proc && last_s1)) |=>
		ip_status_q == $past(ip_status_q))
		else $error("IP status changed within a URL");

	// The prefix matcher stays within its position range or the fail mark.
	a_prefix_range: assert property (@(posedge clk) disable iff (!arst_n)
		prefix_position_q <= PREFIX_DONE || prefix_position_q == PREFIX_FAIL)
		else $error("prefix position out of range");

	// A last byte behind a stalled result must hold off input.
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && out_valid_q && !risk_out.ready) |-> !url_in.ready)
		else $error("input taken while a result is blocked");

	// A loaded result carries a reachable score and a defined verdict.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && last_s1) |=> (score_q <= SCORE_MAX && verdict_q != 2'd3))
		else $error("result out of range");
`endif

endmodule
